/* sv/wqfr_pkg.sv */
// ----------------------------------------------------------------------------
// wqfr_pkg
// Shared types, constants and the byte-wide crc-8 update for the
// water-quality frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wqfr_pkg;

  // frame layout
  localparam int unsigned FRAME_LAST    = 26;
  localparam int unsigned CRC_POS       = 25;
  localparam int unsigned PAYLOAD_FIRST = 8;
  localparam int unsigned PAYLOAD_COUNT = 17;
  localparam int unsigned POS_W         = 5;
  localparam int unsigned PIDX_W        = 5;

  // frame marker bytes
  localparam logic [7:0] HDR_BYTE0    = 8'h55;
  localparam logic [7:0] HDR_BYTE1    = 8'hAA;
  localparam logic [7:0] TRAILER_BYTE = 8'hFF;

  // reflected crc-8 polynomial, maxim form
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // frame status codes
  typedef enum logic [1:0] {
    STATUS_GOOD      = 2'd0,
    STATUS_FRAME_ERR = 2'd1,
    STATUS_CRC_ERR   = 2'd2
  } frame_status_t;

  // input request
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } wqfr_in_t;

  // result request
  typedef struct packed {
    logic [1:0]  frame_status;
    logic [15:0] toc_hundredths;
    logic [15:0] cod_hundredths;
    logic [15:0] sd_hundredths;
    logic [15:0] zd_hundredths;
    logic [15:0] temp_tenths;
    logic [15:0] tds_value;
    logic [15:0] uv254_ten_thousandths;
    logic [15:0] ec_value;
    logic [7:0]  wqi_value;
  } wqfr_out_t;

  // one byte through the crc, lsb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/water_quality_frame_receiver.sv */
// ----------------------------------------------------------------------------
// water_quality_frame_receiver
// Groups sensor response bytes into 27-byte frames, checks header, trailer
// and crc-8, and emits a status with nine big-endian readings per frame.
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// in_       input      in_valid / in_stall    wqfr_in_t  (rx_byte, frame_start)
// out_      output     out_valid / out_stall  wqfr_out_t (status and readings)
//
// One byte per cycle sustained while out_stall is low: a byte is held in the
// input register, then crc, checks and capture run in one pass into the frame
// state and the result register, which takes the result of the trailer byte.
// Reset clears frame position, crc and check flags; payload bytes are not
// cleared. A stall on the output holds the result and backs up into in_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module water_quality_frame_receiver
  import wqfr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_stall,
  input  wire wqfr_in_t  in_data,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      wqfr_out_t out_data
);

  // input register
  logic     in_valid_r;
  wqfr_in_t in_r;

  // frame state
  logic [POS_W-1:0] pos_r,  pos_nxt;
  logic [7:0]       crc_r,  crc_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;
  logic             crc_ok_r, crc_ok_nxt;
  logic [7:0]       payload_r [PAYLOAD_COUNT];

  // result register
  logic      out_valid_r;
  wqfr_out_t out_r, out_nxt;

  logic             advance;
  logic             accept;
  logic [POS_W-1:0] pos;
  logic             emit;
  logic             pay_we;
  logic [POS_W-1:0] pay_off;
  logic [PIDX_W-1:0] pay_idx;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  // input register load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
  end

  // effective position of the byte in the input register
  always_comb begin
    if (in_r.frame_start || (pos_r > POS_W'(FRAME_LAST))) begin
      pos = '0;
    end else begin
      pos = pos_r;
    end
  end

  assign pay_off = pos - POS_W'(PAYLOAD_FIRST);
  assign pay_idx = pay_off[PIDX_W-1:0];
  assign pay_we  = in_valid_r && advance
                   && (pos >= POS_W'(PAYLOAD_FIRST)) && (pos < POS_W'(CRC_POS));
  assign emit    = (pos == POS_W'(FRAME_LAST));

  // header, crc and position update
  always_comb begin
    hdr_ok_nxt = hdr_ok_r;
    crc_ok_nxt = crc_ok_r;
    crc_nxt    = crc_r;
    if (pos == '0) begin
      crc_nxt    = '0;
      crc_ok_nxt = 1'b0;
      hdr_ok_nxt = (in_r.rx_byte == HDR_BYTE0);
    end else if (pos == POS_W'(1)) begin
      hdr_ok_nxt = hdr_ok_r && (in_r.rx_byte == HDR_BYTE1);
    end
    if (pos < POS_W'(CRC_POS)) begin
      crc_nxt = crc8_update(crc_nxt, in_r.rx_byte);
    end
    if (pos == POS_W'(CRC_POS)) begin
      crc_ok_nxt = (crc_r == in_r.rx_byte);
    end
    pos_nxt = emit ? '0 : pos + POS_W'(1);
  end

  // result assembly on the trailer byte
  always_comb begin
    out_nxt = '0;
    if (!hdr_ok_r || (in_r.rx_byte != TRAILER_BYTE)) begin
      out_nxt.frame_status = STATUS_FRAME_ERR;
    end else begin
      out_nxt.frame_status          = crc_ok_r ? STATUS_GOOD : STATUS_CRC_ERR;
      out_nxt.toc_hundredths        = {payload_r[0],  payload_r[1]};
      out_nxt.cod_hundredths        = {payload_r[2],  payload_r[3]};
      out_nxt.sd_hundredths         = {payload_r[4],  payload_r[5]};
      out_nxt.zd_hundredths         = {payload_r[6],  payload_r[7]};
      out_nxt.temp_tenths           = {payload_r[8],  payload_r[9]};
      out_nxt.tds_value             = {payload_r[10], payload_r[11]};
      out_nxt.uv254_ten_thousandths = {payload_r[12], payload_r[13]};
      out_nxt.ec_value              = {payload_r[14], payload_r[15]};
      out_nxt.wqi_value             = payload_r[16];
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      crc_r    <= '0;
      hdr_ok_r <= 1'b0;
      crc_ok_r <= 1'b0;
    end else if (in_valid_r && advance) begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      crc_ok_r <= crc_ok_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (pay_we) begin
      payload_r[pay_idx] <= in_r.rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r && emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the water-quality frame receiver. Sensor frames
// (good, corrupted, cut short, unaligned) and line noise are sent one byte
// per request under random sender gaps and receiver stalls. A bit-exact
// frame tracker predicts each status and reading set, and every result
// is checked field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import wqfr_pkg::*;

  // how the data bytes of a built frame are filled
  typedef enum int unsigned {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_kind_t;

  localparam int unsigned FRAME_LEN    = FRAME_LAST + 1;
  localparam int unsigned RANDOM_BYTES = 1200;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  wqfr_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  wqfr_out_t out_data;

  water_quality_frame_receiver i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 10 ns clock
  always begin
    #5;
    clk = 1'b1;
    #5;
    clk = 1'b0;
  end

  // frame tracker state, mirrors the receiver after reset
  logic [4:0] trk_pos    = '0;
  logic [7:0] trk_crc    = '0;
  logic       trk_hdr_ok = 1'b0;
  logic       trk_crc_ok = 1'b0;
  logic [7:0] trk_payload [PAYLOAD_COUNT] = '{default: 8'h00};

  wqfr_out_t expected_frames [$];

  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned burst_left     = 0;
  bit          tx_idle_on     = 1'b1;
  bit          rx_stall_on    = 1'b1;
  int unsigned stall_left     = 0;
  wqfr_out_t   exp_frame;

  logic [7:0] frame_buf [FRAME_LEN];

  // crc-8 maxim, one input bit at a time
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // crc over bytes 0..24 of the frame buffer
  function automatic logic [7:0] frame_crc();
    logic [7:0] c;
    c = '0;
    for (int i = 0; i < CRC_POS; i++) c = crc_byte(c, frame_buf[i]);
    return c;
  endfunction

  // advance the tracker by one accepted byte, queue a result on the last byte
  task automatic track_frame_byte(input logic [7:0] b, input logic start);
    int unsigned p;
    wqfr_out_t   r;
    p = trk_pos;
    if (start || p > FRAME_LAST) p = 0;
    if (p == 0) begin
      trk_crc    = '0;
      trk_crc_ok = 1'b0;
      trk_hdr_ok = (b == HDR_BYTE0);
    end else if (p == 1) begin
      trk_hdr_ok = trk_hdr_ok && (b == HDR_BYTE1);
    end
    if (p < CRC_POS) trk_crc = crc_byte(trk_crc, b);
    if (p >= PAYLOAD_FIRST && p < CRC_POS) trk_payload[p - PAYLOAD_FIRST] = b;
    if (p == CRC_POS) trk_crc_ok = (trk_crc == b);
    if (p < FRAME_LAST) begin
      trk_pos = 5'(p + 1);
    end else begin
      trk_pos = '0;
      r = '0;
      if (!trk_hdr_ok || b != TRAILER_BYTE) begin
        r.frame_status = STATUS_FRAME_ERR;
      end else begin
        r.frame_status          = trk_crc_ok ? STATUS_GOOD : STATUS_CRC_ERR;
        r.toc_hundredths        = {trk_payload[0], trk_payload[1]};
        r.cod_hundredths        = {trk_payload[2], trk_payload[3]};
        r.sd_hundredths         = {trk_payload[4], trk_payload[5]};
        r.zd_hundredths         = {trk_payload[6], trk_payload[7]};
        r.temp_tenths           = {trk_payload[8], trk_payload[9]};
        r.tds_value             = {trk_payload[10], trk_payload[11]};
        r.uv254_ten_thousandths = {trk_payload[12], trk_payload[13]};
        r.ec_value              = {trk_payload[14], trk_payload[15]};
        r.wqi_value             = trk_payload[16];
      end
      expected_frames.push_back(r);
    end
  endtask

  // send one byte request, bursts with random gaps between them when idling is on
  task automatic send_byte(input logic [7:0] b, input logic start);
    int unsigned gap;
    wqfr_in_t    d;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (tx_idle_on) begin
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    d.rx_byte     = b;
    d.frame_start = start;
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    track_frame_byte(b, start);
  endtask

  // well-formed frame in the buffer
  task automatic make_frame(input fill_kind_t fill);
    frame_buf[0] = HDR_BYTE0;
    frame_buf[1] = HDR_BYTE1;
    for (int i = 2; i < CRC_POS; i++) begin
      case (fill)
        FILL_ZERO: frame_buf[i] = 8'h00;
        FILL_ONES: frame_buf[i] = 8'hFF;
        default:   frame_buf[i] = 8'($urandom);
      endcase
    end
    frame_buf[CRC_POS]    = frame_crc();
    frame_buf[FRAME_LAST] = TRAILER_BYTE;
  endtask

  // send the first n bytes of the buffer, start flag on byte 0 if asked
  task automatic send_frame(input bit with_start, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_byte(frame_buf[i], with_start && i == 0);
  endtask

  // flip one random bit of a byte
  function automatic logic [7:0] flip_bit(input logic [7:0] b);
    return b ^ (8'h01 << $urandom_range(0, 7));
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endtask

  // receiver stall pattern: short and occasional long stalls between free runs
  always @(posedge clk) begin
    if (stall_left == 0) begin
      if (out_stall || !rx_stall_on) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 16);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(0, 4);
      end
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_frames.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with none expected: %h", $time, out_data);
      end else begin
        exp_frame = expected_frames.pop_front();
        check_field("frame_status", 16'(exp_frame.frame_status), 16'(out_data.frame_status));
        check_field("toc_hundredths", exp_frame.toc_hundredths, out_data.toc_hundredths);
        check_field("cod_hundredths", exp_frame.cod_hundredths, out_data.cod_hundredths);
        check_field("sd_hundredths", exp_frame.sd_hundredths, out_data.sd_hundredths);
        check_field("zd_hundredths", exp_frame.zd_hundredths, out_data.zd_hundredths);
        check_field("temp_tenths", exp_frame.temp_tenths, out_data.temp_tenths);
        check_field("tds_value", exp_frame.tds_value, out_data.tds_value);
        check_field("uv254_ten_thousandths", exp_frame.uv254_ten_thousandths,
                    out_data.uv254_ten_thousandths);
        check_field("ec_value", exp_frame.ec_value, out_data.ec_value);
        check_field("wqi_value", 16'(exp_frame.wqi_value), 16'(out_data.wqi_value));
      end
    end
  end

  // readings at both extremes and a random set, back to back with no idling
  task automatic test_extreme_readings();
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
    make_frame(FILL_ZERO);
    send_frame(1'b1, FRAME_LEN);
    make_frame(FILL_ONES);
    send_frame(1'b1, FRAME_LEN);
    make_frame(FILL_RANDOM);
    send_frame(1'b1, FRAME_LEN);
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
  endtask

  // header, trailer and crc faults, and header fault taking priority over crc
  task automatic test_frame_faults();
    make_frame(FILL_RANDOM);
    frame_buf[0]       = flip_bit(frame_buf[0]);
    frame_buf[CRC_POS] = frame_crc();
    send_frame(1'b1, FRAME_LEN);
    make_frame(FILL_RANDOM);
    frame_buf[1]       = flip_bit(frame_buf[1]);
    frame_buf[CRC_POS] = frame_crc();
    send_frame(1'b1, FRAME_LEN);
    make_frame(FILL_RANDOM);
    frame_buf[FRAME_LAST] = flip_bit(frame_buf[FRAME_LAST]);
    send_frame(1'b1, FRAME_LEN);
    make_frame(FILL_RANDOM);
    frame_buf[CRC_POS] = flip_bit(frame_buf[CRC_POS]);
    send_frame(1'b1, FRAME_LEN);
    make_frame(FILL_ONES);
    frame_buf[1]       = 8'h00;
    frame_buf[CRC_POS] = flip_bit(frame_buf[CRC_POS]);
    send_frame(1'b1, FRAME_LEN);
  endtask

  // start flag mid-frame drops the partial frame; no flag keeps alignment
  task automatic test_realign();
    make_frame(FILL_RANDOM);
    send_frame(1'b1, 10);
    make_frame(FILL_RANDOM);
    send_frame(1'b1, FRAME_LAST);
    make_frame(FILL_RANDOM);
    send_frame(1'b1, FRAME_LEN);
    make_frame(FILL_RANDOM);
    send_frame(1'b0, FRAME_LEN);
  endtask

  // mostly well-formed frames with random content, some damage and noise
  task automatic test_random_traffic();
    int unsigned pick;
    int unsigned n;
    int unsigned first;
    bit          with_start;
    first = bytes_sent;
    while (bytes_sent - first < RANDOM_BYTES) begin
      if ($urandom_range(0, 19) == 0) begin
        tx_idle_on  = $urandom_range(0, 2) != 0;
        rx_stall_on = $urandom_range(0, 2) != 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        make_frame(FILL_RANDOM);
        case ($urandom_range(0, 19))
          0:       frame_buf[$urandom_range(0, 1)] = 8'($urandom);
          1:       frame_buf[FRAME_LAST] = 8'($urandom);
          2, 3:    frame_buf[CRC_POS] = flip_bit(frame_buf[CRC_POS]);
          4:       frame_buf[$urandom_range(2, CRC_POS - 1)] ^= 8'($urandom_range(1, 255));
          default: ;
        endcase
        with_start = !(trk_pos == 0 && $urandom_range(0, 3) == 0);
        send_frame(with_start, FRAME_LEN);
      end else if (pick < 82) begin
        make_frame(FILL_RANDOM);
        send_frame(1'b1, $urandom_range(1, FRAME_LAST));
      end else begin
        n = $urandom_range(1, 12);
        repeat (n) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end
    end
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
  endtask

  // main sequence
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_extreme_readings();
    test_frame_faults();
    test_realign();
    test_random_traffic();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run time limit
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* files.f */
sv/wqfr_pkg.sv
sv/water_quality_frame_receiver.sv
tb/tb_top.sv
